// ===== hdl/bcg_pkg.sv =====
package bcg_pkg;

    localparam int HoldW  = 12;
    localparam int GapW   = 6;
    localparam int BurstW = 11;
    localparam int EdgeW  = 7;
    localparam int BmaxW  = 10;
    localparam int NeedW  = 6;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 12;

    localparam logic [NeedW-1:0]  RstEdgesNeeded  = 6'd20;
    localparam logic [BmaxW-1:0]  RstBurstMax     = 10'd500;
    localparam logic [BmaxW-1:0]  RstBurstMin     = 10'd200;
    localparam logic [GapW-1:0]   RstGapMin       = 6'd3;
    localparam logic [GapW-1:0]   RstGapMax       = 6'd30;
    localparam logic [HoldW-1:0]  RstHoldPowerOn  = 12'd5;
    localparam logic [HoldW-1:0]  RstHoldPowerOff = 12'd250;
    localparam logic [HoldW-1:0]  RstHoldFactory  = 12'd2800;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_EDGES_NEEDED   = 3'd0,
        CFG_BURST_MAX      = 3'd1,
        CFG_BURST_MIN      = 3'd2,
        CFG_GAP_MIN        = 3'd3,
        CFG_GAP_MAX        = 3'd4,
        CFG_HOLD_POWER_ON  = 3'd5,
        CFG_HOLD_POWER_OFF = 3'd6,
        CFG_HOLD_FACTORY   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [NeedW-1:0]  edges_needed;
        logic [BmaxW-1:0]  burst_window_max;
        logic [BmaxW-1:0]  burst_window_min;
        logic [GapW-1:0]   gap_min;
        logic [GapW-1:0]   gap_max;
        logic [HoldW-1:0]  hold_power_on;
        logic [HoldW-1:0]  hold_power_off;
        logic [HoldW-1:0]  hold_factory_reset;
    } t_cfg;

    typedef struct packed {
        logic stop_motor;
        logic power_on_event;
        logic power_off_event;
        logic lock_event;
        logic unlock_event;
        logic factory_reset_event;
        logic is_locked;
        logic is_powered_off;
    } t_result;

    typedef struct packed {
        logic [EdgeW-1:0]  edge_count;
        logic [GapW-1:0]   gap_ticks;
        logic [BurstW-1:0] burst_ticks;
    } t_burst;

    function automatic logic [HoldW-1:0] f_hold_inc(logic [HoldW-1:0] v);
        return (v == '1) ? v : v + HoldW'(1);
    endfunction

    function automatic logic f_hold_hit(logic [HoldW-1:0] v, logic [HoldW-1:0] thr);
        return (thr != '0) && (v == thr);
    endfunction

    function automatic t_burst f_count_edge(t_burst b, logic [GapW-1:0] gmin);
        t_burst r;
        r = b;
        if (b.gap_ticks > gmin) begin
            r.edge_count = (b.edge_count == '1) ? b.edge_count : b.edge_count + EdgeW'(1);
        end else begin
            r.edge_count  = '0;
            r.burst_ticks = '0;
        end
        r.gap_ticks = '0;
        return r;
    endfunction

    function automatic t_burst f_advance(t_burst b, logic [BmaxW-1:0] bmax,
                                         logic [GapW-1:0] gmax);
        t_burst r;
        r = b;
        r.gap_ticks   = (b.gap_ticks == '1) ? b.gap_ticks : b.gap_ticks + GapW'(1);
        r.burst_ticks = (b.burst_ticks == '1) ? b.burst_ticks
                                              : b.burst_ticks + BurstW'(1);
        if ((r.burst_ticks > {1'b0, bmax}) || (r.gap_ticks > gmax)) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ===== hdl/bcg_if.sv =====
interface bcg_in_if;
    logic valid;
    logic ready;
    logic button_down;
    modport source (output valid, output button_down, input ready);
    modport sink (input valid, input button_down, output ready);
endinterface

interface bcg_out_if;
    logic valid;
    logic ready;
    logic stop_motor;
    logic power_on_event;
    logic power_off_event;
    logic lock_event;
    logic unlock_event;
    logic factory_reset_event;
    logic is_locked;
    logic is_powered_off;
    modport source (output valid, output stop_motor, output power_on_event,
                    output power_off_event, output lock_event, output unlock_event,
                    output factory_reset_event, output is_locked,
                    output is_powered_off, input ready);
    modport sink (input valid, input stop_motor, input power_on_event,
                  input power_off_event, input lock_event, input unlock_event,
                  input factory_reset_event, input is_locked,
                  input is_powered_off, output ready);
endinterface

interface bcg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bcg_cfg.sv =====
module bcg_cfg
    import bcg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcg_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_EDGES_NEEDED:   n_cfg.edges_needed       = i_cfg.data[NeedW-1:0];
                CFG_BURST_MAX:      n_cfg.burst_window_max   = i_cfg.data[BmaxW-1:0];
                CFG_BURST_MIN:      n_cfg.burst_window_min   = i_cfg.data[BmaxW-1:0];
                CFG_GAP_MIN:        n_cfg.gap_min            = i_cfg.data[GapW-1:0];
                CFG_GAP_MAX:        n_cfg.gap_max            = i_cfg.data[GapW-1:0];
                CFG_HOLD_POWER_ON:  n_cfg.hold_power_on      = i_cfg.data[HoldW-1:0];
                CFG_HOLD_POWER_OFF: n_cfg.hold_power_off     = i_cfg.data[HoldW-1:0];
                CFG_HOLD_FACTORY:   n_cfg.hold_factory_reset = i_cfg.data[HoldW-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edges_needed       <= RstEdgesNeeded;
            r_cfg.burst_window_max   <= RstBurstMax;
            r_cfg.burst_window_min   <= RstBurstMin;
            r_cfg.gap_min            <= RstGapMin;
            r_cfg.gap_max            <= RstGapMax;
            r_cfg.hold_power_on      <= RstHoldPowerOn;
            r_cfg.hold_power_off     <= RstHoldPowerOff;
            r_cfg.hold_factory_reset <= RstHoldFactory;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hdl/bcg_core.sv =====
module bcg_core
    import bcg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_fire,
    input  logic    i_level,
    output t_result o_result
);

    logic             r_prev;
    logic [HoldW-1:0] r_hold;
    t_burst           r_burst;
    logic             r_long_press;
    logic             r_locked;
    logic             r_powered_off;

    logic             n_prev;
    logic [HoldW-1:0] n_hold;
    t_burst           n_burst;
    logic             n_long_press;
    logic             n_locked;
    logic             n_powered_off;
    t_result          n_res;

    always_comb begin
        n_prev        = i_level;
        n_hold        = r_hold;
        n_burst       = r_burst;
        n_long_press  = r_long_press;
        n_locked      = r_locked;
        n_powered_off = r_powered_off;
        n_res         = '0;
        unique case ({i_level, r_prev})
            2'b10: begin
                // press
                n_res.stop_motor = 1'b1;
                n_burst = f_advance(f_count_edge(r_burst, i_cfg.gap_min),
                                    i_cfg.burst_window_max, i_cfg.gap_max);
                n_hold  = '0;
            end
            2'b01: begin
                // release
                n_hold  = '0;
                n_burst = f_count_edge(r_burst, i_cfg.gap_min);
                if ((n_burst.edge_count >= {1'b0, i_cfg.edges_needed})
                        && (n_burst.burst_ticks > {1'b0, i_cfg.burst_window_min})) begin
                    n_burst.edge_count = '0;
                    n_locked           = !r_locked;
                    n_powered_off      = !r_locked;
                    n_res.lock_event   = !r_locked;
                    n_res.unlock_event = r_locked;
                end else begin
                    if (n_burst.edge_count >= {1'b0, i_cfg.edges_needed}) begin
                        n_burst.edge_count  = '0;
                        n_burst.burst_ticks = '0;
                    end
                    if (r_long_press) begin
                        n_long_press = 1'b0;
                    end else if (!r_powered_off) begin
                        n_res.stop_motor = 1'b1;
                    end
                end
            end
            2'b11: begin
                // held
                n_hold  = f_hold_inc(r_hold);
                n_burst = f_advance(r_burst, i_cfg.burst_window_max, i_cfg.gap_max);
                if (!r_locked) begin
                    if (f_hold_hit(n_hold, i_cfg.hold_power_off)) begin
                        n_hold = f_hold_inc(n_hold);
                        if (!n_powered_off) begin
                            n_powered_off         = 1'b1;
                            n_res.power_off_event = 1'b1;
                        end
                        n_long_press = 1'b1;
                    end
                    if (f_hold_hit(n_hold, i_cfg.hold_factory_reset)) begin
                        n_hold                    = f_hold_inc(n_hold);
                        n_res.factory_reset_event = 1'b1;
                        n_long_press              = 1'b1;
                    end
                    if (f_hold_hit(n_hold, i_cfg.hold_power_on)) begin
                        n_hold = f_hold_inc(n_hold);
                        if (n_powered_off) begin
                            n_powered_off        = 1'b0;
                            n_res.power_on_event = 1'b1;
                        end
                        n_long_press = 1'b1;
                    end
                end
            end
            default: begin
                // idle
                n_burst = f_advance(r_burst, i_cfg.burst_window_max, i_cfg.gap_max);
                n_hold  = '0;
            end
        endcase
        n_res.is_locked      = n_locked;
        n_res.is_powered_off = n_powered_off;
    end

    assign o_result = n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= 1'b0;
            r_hold        <= '0;
            r_burst       <= '0;
            r_long_press  <= 1'b0;
            r_locked      <= 1'b0;
            r_powered_off <= 1'b1;
        end else if (i_fire) begin
            r_prev        <= n_prev;
            r_hold        <= n_hold;
            r_burst       <= n_burst;
            r_long_press  <= n_long_press;
            r_locked      <= n_locked;
            r_powered_off <= n_powered_off;
        end
    end

endmodule

// ===== hdl/button_click_and_hold_gesture_core.sv =====
// Button gesture detector: one sampled button level per word on the input
// channel, one result word per input word on the output channel, in order.
// A word passes an input register, combinational gesture logic and a result
// register; it moves from the input register into the result register only
// when the output is not stalled. A new word is taken every cycle while the
// output is not stalled. The gesture state updates as each word moves into
// the result register. The configuration port is always ready; the user must
// see that it is written only while no word is in flight, as the block does not enforce this.
module button_click_and_hold_gesture_core
    import bcg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcg_in_if.sink     i_in,
    bcg_out_if.source  o_out,
    bcg_cfg_if.sink    i_cfg
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_fire;

    logic    r_in_valid;
    logic    r_in_level;
    logic    r_out_valid;
    t_result r_out;

    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    bcg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    bcg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_fire),
        .i_level  (r_in_level),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_level <= i_in.button_down;
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.stop_motor          = r_out.stop_motor;
    assign o_out.power_on_event      = r_out.power_on_event;
    assign o_out.power_off_event     = r_out.power_off_event;
    assign o_out.lock_event          = r_out.lock_event;
    assign o_out.unlock_event        = r_out.unlock_event;
    assign o_out.factory_reset_event = r_out.factory_reset_event;
    assign o_out.is_locked           = r_out.is_locked;
    assign o_out.is_powered_off      = r_out.is_powered_off;

    a_lock_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.lock_event && r_out.unlock_event))
        else $error("lock and unlock in one word");

    a_lock_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.lock_event) |-> (r_out.is_locked && r_out.is_powered_off))
        else $error("lock without locked and off flags");

    a_unlock_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.unlock_event) |-> (!r_out.is_locked && !r_out.is_powered_off))
        else $error("unlock without cleared flags");

    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("result word lost");

endmodule
